/* hw/rtl/ufsc_pkg.sv */
package ufsc_pkg;

    // Frame layout, byte offsets counted from the first byte on the wire.
    localparam int unsigned POS_W       = 6;
    localparam int unsigned HDR_ETH     = 14;
    localparam int unsigned HDR_IP_END  = 34;
    localparam int unsigned HDR_UDP_END = 42;

    localparam logic [POS_W-1:0] OFF_TYPE_HI  = POS_W'(12);
    localparam logic [POS_W-1:0] OFF_TYPE_LO  = POS_W'(13);
    localparam logic [POS_W-1:0] OFF_PROTO    = POS_W'(23);
    localparam logic [POS_W-1:0] OFF_DADDR_3  = POS_W'(30);
    localparam logic [POS_W-1:0] OFF_DADDR_2  = POS_W'(31);
    localparam logic [POS_W-1:0] OFF_DADDR_1  = POS_W'(32);
    localparam logic [POS_W-1:0] OFF_DADDR_0  = POS_W'(33);
    localparam logic [POS_W-1:0] OFF_SPORT_HI = POS_W'(34);
    localparam logic [POS_W-1:0] OFF_SPORT_LO = POS_W'(35);
    localparam logic [POS_W-1:0] OFF_DPORT_HI = POS_W'(36);
    localparam logic [POS_W-1:0] OFF_DPORT_LO = POS_W'(37);

    localparam logic [15:0] TYPE_IPV4 = 16'h0800;
    localparam logic [15:0] TYPE_ARP  = 16'h0806;
    localparam logic [7:0]  PROTO_UDP = 8'd17;

    // Field widths.
    localparam int unsigned QUEUE_W = 10;
    localparam int unsigned DIV_W   = 11;
    localparam int unsigned PORT_W  = 16;
    localparam int unsigned SOCK_W  = 10;
    localparam int unsigned IDX_W   = QUEUE_W + DIV_W + 1;
    localparam int unsigned STEP_W  = $clog2(PORT_W);

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_BIND_ADDR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIND_PORT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SOCK_PER_Q = 2'd2;

    typedef enum logic [1:0] {
        V_ABORT    = 2'd0,
        V_PASS     = 2'd1,
        V_REDIRECT = 2'd2
    } t_verdict;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EVAL = 5'b00010,
        S_DIV  = 5'b00100,
        S_MUL  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_byte;
        logic eval;
        logic div_step;
        logic mul;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic steer;
        logic div_last;
        logic out_free;
    } t_stat;

endpackage

/* hw/rtl/udp_flow_steering_classifier_top.sv */
// Frame bytes are taken one per cycle while the block is between verdicts.
// After a frame's last byte, input stalls: the verdict is registered after an evaluate state for
// aborted or passed frames, and after the evaluate state, a 16-step bit-serial remainder unit
// and a multiply-add state for steered frames; it waits longer if the output is held.
// Reset (i_rst_n low, synchronous) clears the byte count, the captured header,
// the output valid and the bind registers; sockets_per_queue resets to 1.
module udp_flow_steering_classifier_top #(
    parameter int unsigned MAP_ENTRIES = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Byte stream in.
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [7:0]                         s_axis_tdata,  // [7:0] frame_byte
    input  logic                               s_axis_tlast,  // last_byte
    input  logic [ufsc_pkg::QUEUE_W-1:0]       s_axis_tuser,  // [9:0] queue_number
    // Verdict out.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [15:0]                        m_axis_tdata,  // [9:0] socket_index
    output logic [1:0]                         m_axis_tuser,  // [1:0] verdict
    // Configuration writes.
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ufsc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [31:0]                        i_cfg_data
);
    import ufsc_pkg::*;

    t_cmd              cmd;
    t_stat             stat;
    t_verdict          verdict;
    logic [SOCK_W-1:0] socket_index;

    assign o_cfg_ready = 1'b1;

    ufsc_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (s_axis_tvalid),
        .i_byte_last  (s_axis_tlast),
        .o_byte_ready (s_axis_tready),
        .i_stat       (stat),
        .o_cmd        (cmd)
    );

    ufsc_dpath #(
        .MAP_ENTRIES (MAP_ENTRIES)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_frame_byte   (s_axis_tdata),
        .i_last_byte    (s_axis_tlast),
        .i_queue_number (s_axis_tuser),
        .i_cfg_write    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_verdict      (verdict),
        .o_socket_index (socket_index)
    );

    assign m_axis_tuser = verdict;
    assign m_axis_tdata = {(16 - SOCK_W)'(0), socket_index};

endmodule

/* hw/rtl/ufsc_ctrl.sv */
module ufsc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_byte_valid,
    input  logic           i_byte_last,
    output logic           o_byte_ready,
    input  ufsc_pkg::t_stat i_stat,
    output ufsc_pkg::t_cmd  o_cmd
);
    import ufsc_pkg::*;

    t_state r_state;
    t_state n_state;

    // Bytes are taken only while no verdict is being worked out.
    assign o_byte_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd           = '0;
        o_cmd.take_byte = (r_state == S_IDLE) && i_byte_valid;
        o_cmd.eval      = (r_state == S_EVAL);
        o_cmd.div_step  = (r_state == S_DIV);
        o_cmd.mul       = (r_state == S_MUL);
        o_cmd.out_load  = (r_state == S_OUT) && i_stat.out_free;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_byte_valid && i_byte_last) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = i_stat.steer ? S_DIV : S_OUT;
            end
            S_DIV: begin
                if (i_stat.div_last) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // The divider runs its full count before the multiply.
    a_div_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && !i_stat.div_last) |=> (r_state == S_DIV))
        else $error("divider left before its last step");

    // A last byte always starts an evaluation.
    a_last_evals: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.take_byte && i_byte_last) |=> (r_state == S_EVAL))
        else $error("last byte did not start evaluation");

    // A free output register takes the verdict and the block goes back to bytes.
    a_out_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && i_stat.out_free) |=> (r_state == S_IDLE))
        else $error("verdict not handed over");

endmodule

/* hw/rtl/ufsc_dpath.sv */
module ufsc_dpath #(
    parameter int unsigned MAP_ENTRIES = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ufsc_pkg::t_cmd                     i_cmd,
    output ufsc_pkg::t_stat                    o_stat,
    // Incoming item fields.
    input  logic [7:0]                         i_frame_byte,
    input  logic                               i_last_byte,
    input  logic [ufsc_pkg::QUEUE_W-1:0]       i_queue_number,
    // Configuration writes.
    input  logic                               i_cfg_write,
    input  logic [ufsc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [31:0]                        i_cfg_data,
    // Result register.
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output ufsc_pkg::t_verdict                 o_verdict,
    output logic [ufsc_pkg::SOCK_W-1:0]        o_socket_index
);
    import ufsc_pkg::*;

    // Configuration registers.
    logic [31:0]        r_bind_addr;
    logic [PORT_W-1:0]  r_bind_port;
    logic [DIV_W-1:0]   r_sock_per_q;

    // Header capture.
    logic [POS_W-1:0]   r_pos;
    logic [POS_W-1:0]   r_len;
    logic [15:0]        r_type;
    logic [7:0]         r_proto;
    logic [31:0]        r_daddr;
    logic [PORT_W-1:0]  r_sport;
    logic [PORT_W-1:0]  r_dport;
    logic [QUEUE_W-1:0] r_queue;

    // Steering arithmetic.
    t_verdict           r_pre_verdict;
    logic               r_steer;
    logic [PORT_W-1:0]  r_dividend;
    logic [DIV_W-1:0]   r_rem;
    logic [STEP_W-1:0]  r_step;
    logic [IDX_W-1:0]   r_idx;

    // Result register.
    logic               r_o_valid;
    t_verdict           r_o_verdict;
    logic [SOCK_W-1:0]  r_o_index;

    logic [POS_W-1:0]   n_len;
    logic [DIV_W-1:0]   div_eff;
    t_verdict           eval_verdict;
    logic               eval_steer;
    logic [PORT_W-1:0]  eval_port;
    logic [DIV_W:0]     rem_sh;
    logic [DIV_W-1:0]   n_rem;
    logic [IDX_W-1:0]   n_idx;
    t_verdict           fin_verdict;
    logic [SOCK_W-1:0]  fin_index;

    // A divisor of zero counts as one.
    assign div_eff = (r_sock_per_q == '0) ? DIV_W'(1) : r_sock_per_q;

    // Byte count after this byte, held at the end of the UDP header.
    assign n_len = (r_pos >= POS_W'(HDR_UDP_END)) ? POS_W'(HDR_UDP_END) : r_pos + POS_W'(1);

    // Frame classification from the captured header.
    always_comb begin
        eval_verdict = V_PASS;
        eval_steer   = 1'b0;
        eval_port    = '0;
        if (r_len < POS_W'(HDR_ETH)) begin
            eval_verdict = V_ABORT;
        end else if (r_type == TYPE_IPV4) begin
            if (r_len < POS_W'(HDR_IP_END)) begin
                eval_verdict = V_ABORT;
            end else if (r_daddr != r_bind_addr || r_proto != PROTO_UDP) begin
                eval_verdict = V_PASS;
            end else if (r_len < POS_W'(HDR_UDP_END)) begin
                eval_verdict = V_ABORT;
            end else if (r_dport != r_bind_port) begin
                eval_verdict = V_PASS;
            end else begin
                eval_steer = 1'b1;
                eval_port  = r_sport;
            end
        end else if (r_type == TYPE_ARP) begin
            eval_steer = 1'b1;
        end
    end

    // One restoring division step per cycle, most significant bit first.
    assign rem_sh = {r_rem, r_dividend[PORT_W-1]};
    assign n_rem  = (rem_sh >= {1'b0, div_eff}) ? DIV_W'(rem_sh - {1'b0, div_eff})
                                                 : DIV_W'(rem_sh);

    assign n_idx = IDX_W'(r_queue) * IDX_W'(div_eff) + IDX_W'(r_rem);

    // Final verdict once the index is known.
    always_comb begin
        fin_verdict = r_pre_verdict;
        fin_index   = '0;
        if (r_steer) begin
            if (r_idx < IDX_W'(MAP_ENTRIES)) begin
                fin_verdict = V_REDIRECT;
                fin_index   = r_idx[SOCK_W-1:0];
            end else begin
                fin_verdict = V_PASS;
            end
        end
    end

    assign o_stat.steer    = eval_steer;
    assign o_stat.div_last = (r_step == STEP_W'(PORT_W - 1));
    assign o_stat.out_free = !r_o_valid || i_out_ready;

    assign o_out_valid    = r_o_valid;
    assign o_verdict      = r_o_verdict;
    assign o_socket_index = r_o_index;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bind_addr  <= '0;
            r_bind_port  <= '0;
            r_sock_per_q <= DIV_W'(1);
        end else if (i_cfg_write) begin
            unique case (i_cfg_index)
                REG_BIND_ADDR:  r_bind_addr  <= i_cfg_data;
                REG_BIND_PORT:  r_bind_port  <= i_cfg_data[PORT_W-1:0];
                REG_SOCK_PER_Q: r_sock_per_q <= i_cfg_data[DIV_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Byte counter and header capture at fixed offsets.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_len   <= '0;
            r_type  <= '0;
            r_proto <= '0;
            r_daddr <= '0;
            r_sport <= '0;
            r_dport <= '0;
            r_queue <= '0;
        end else if (i_cmd.take_byte) begin
            if (r_pos == '0) begin
                r_queue <= i_queue_number;
            end
            unique case (r_pos)
                OFF_TYPE_HI:  r_type[15:8]   <= i_frame_byte;
                OFF_TYPE_LO:  r_type[7:0]    <= i_frame_byte;
                OFF_PROTO:    r_proto        <= i_frame_byte;
                OFF_DADDR_3:  r_daddr[31:24] <= i_frame_byte;
                OFF_DADDR_2:  r_daddr[23:16] <= i_frame_byte;
                OFF_DADDR_1:  r_daddr[15:8]  <= i_frame_byte;
                OFF_DADDR_0:  r_daddr[7:0]   <= i_frame_byte;
                OFF_SPORT_HI: r_sport[15:8]  <= i_frame_byte;
                OFF_SPORT_LO: r_sport[7:0]   <= i_frame_byte;
                OFF_DPORT_HI: r_dport[15:8]  <= i_frame_byte;
                OFF_DPORT_LO: r_dport[7:0]   <= i_frame_byte;
                default: begin
                end
            endcase
            if (i_last_byte) begin
                r_len <= n_len;
                r_pos <= '0;
            end else begin
                r_pos <= n_len;
            end
        end
    end

    // Steering: classify, divide, then multiply and add.
    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_pre_verdict <= eval_verdict;
            r_steer       <= eval_steer;
            r_dividend    <= eval_port;
            r_rem         <= '0;
            r_step        <= '0;
        end else if (i_cmd.div_step) begin
            r_dividend <= {r_dividend[PORT_W-2:0], 1'b0};
            r_rem      <= n_rem;
            r_step     <= r_step + STEP_W'(1);
        end
        if (i_cmd.mul) begin
            r_idx <= n_idx;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_verdict <= fin_verdict;
            r_o_index   <= fin_index;
        end
    end

    a_pos_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(HDR_UDP_END))
        else $error("byte count beyond header end");

    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_verdict != V_REDIRECT) |-> (r_o_index == '0))
        else $error("socket index set without redirect");

    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> r_o_valid)
        else $error("loaded verdict not shown");

endmodule
